### sv/delta_list_task_scheduler_assert.svh
// Assertion macros for the delta list task scheduler.
// Used by the top level only; relies on i_clk and i_rst_n in scope.
`ifndef DELTA_LIST_TASK_SCHEDULER_ASSERT_SVH
`define DELTA_LIST_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DLTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, checked outside reset.
`define DLTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

### sv/dlts_pkg.sv
// Shared types and constants of the delta list task scheduler.
// No dependencies; used by the interfaces and all modules.
package dlts_pkg;
    localparam int CMD_W  = 2;
    localparam int DATA_W = 32;
    localparam int HDL_W  = 16;
    localparam int TID_W  = 4;
    localparam int ST_W   = 2;
    localparam int TICK_W = 10;

    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(10);

    typedef logic [CMD_W-1:0] t_cmd;
    typedef logic [ST_W-1:0]  t_status;

    localparam t_cmd CMD_TICK     = 2'd0;
    localparam t_cmd CMD_ADD      = 2'd1;
    localparam t_cmd CMD_DELETE   = 2'd2;
    localparam t_cmd CMD_DISPATCH = 2'd3;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_NO_ID   = 2'd2;
    localparam t_status ST_NOT_DUE = 2'd3;
endpackage

### sv/dlts_in_if.sv
// Command channel of the scheduler: valid/ready plus one command word.
// Depends on dlts_pkg.
interface dlts_in_if;
    import dlts_pkg::*;
    logic              valid;
    logic              ready;
    t_cmd              command;
    logic [DATA_W-1:0] delay_ms;
    logic [DATA_W-1:0] period_ms;
    logic [HDL_W-1:0]  handle;
    logic [TID_W-1:0]  target_id;

    modport source (output valid, command, delay_ms, period_ms, handle, target_id,
                    input ready);
    modport sink (input valid, command, delay_ms, period_ms, handle, target_id,
                  output ready);
endinterface

### sv/dlts_out_if.sv
// Result channel of the scheduler: valid/ready plus one result word.
// Depends on dlts_pkg.
interface dlts_out_if;
    import dlts_pkg::*;
    logic             valid;
    logic             ready;
    t_status          status;
    logic [TID_W-1:0] task_id;
    logic             fired;
    logic [HDL_W-1:0] fired_handle;

    modport source (output valid, status, task_id, fired, fired_handle, input ready);
    modport sink (input valid, status, task_id, fired, fired_handle, output ready);
endinterface

### sv/delta_list_task_scheduler.sv
// Delta list timer task queue. One command word enters on i_in (valid/ready),
// one result word leaves on o_out for every command. The block works on one
// word at a time: i_in.ready is high only while the sequencer is idle.
// Tasks live in a linked list whose entries hold the delay relative to their
// predecessor, so a tick touches only the head entry.
// Steps per word after the idle state accepts it: tick decrements the head
// delta, or marks the head due at zero. Delete walks the list to the target,
// adds its delta to the successor when there is one, then unlinks it. Add
// searches up to MAX_TASKS ids for a free one, runs two divisions on the
// shared divider, walks the list, writes and links the entry. Dispatch unlinks
// the head; a periodic task adds a re-insert walk. Throughput is set by the divider
// and the list walks, which read the single task memory port one entry per cycle.
// The result sits in an output register; the next word is accepted once the
// result has been loaded there, so a stalled receiver holds the block only
// when a second result is ready before the first is taken.
// Reset (synchronous, active low) empties the list, frees all ids, sets tick_ms
// to 10 and clears any pending result. Entry memories are not cleared; an entry
// is read only after it has been written by an add. The user must write tick_ms
// via i_cfg_we/i_cfg_wdata while the block is idle; the block does not enforce it.
`include "delta_list_task_scheduler_assert.svh"

module delta_list_task_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dlts_in_if.sink                     i_in,
    dlts_out_if.source                  o_out,
    input  logic                        i_cfg_we,
    input  logic [dlts_pkg::TICK_W-1:0] i_cfg_wdata
);
    import dlts_pkg::*;

    localparam int IDW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int PW  = $clog2(MAX_TASKS + 1);
    localparam logic [PW-1:0] NO_TASK = PW'(MAX_TASKS);
    localparam logic [PW-1:0] LAST_ID = PW'(MAX_TASKS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_DIV_D, S_DIV_P, S_L_WALK, S_L_ENT, S_L_LNK,
        S_U_WALK, S_U_ADD, S_U_FIX, S_T_EX, S_D_HEAD, S_OUT
    } t_state;

    // Entry memories, read at the next cursor value every cycle.
    logic [PW-1:0]     mem_succ  [MAX_TASKS];
    logic [DATA_W-1:0] mem_delta [MAX_TASKS];
    logic [DATA_W-1:0] mem_per   [MAX_TASKS];
    logic [HDL_W-1:0]  mem_hdl   [MAX_TASKS];

    logic [PW-1:0]     rd_succ;
    logic [DATA_W-1:0] rd_delta;
    logic [DATA_W-1:0] rd_per;
    logic [HDL_W-1:0]  rd_hdl;

    t_state            r_state;
    t_cmd              r_cmd;
    logic [MAX_TASKS-1:0] r_in_use;
    logic [PW-1:0]     r_head;
    logic [PW-1:0]     r_count;
    logic [IDW-1:0]    r_last;
    logic              r_due;
    logic [TICK_W-1:0] r_tick;

    logic [PW-1:0]     r_cur, n_cur;
    logic [PW-1:0]     r_prev;
    logic [PW-1:0]     r_nxt;
    logic [IDW-1:0]    r_id;
    logic [PW-1:0]     r_n;
    logic [DATA_W-1:0] r_sum;
    logic [DATA_W-1:0] r_d;
    logic [DATA_W-1:0] r_p;
    logic [DATA_W-1:0] r_nd;
    logic [DATA_W-1:0] r_did;
    logic [HDL_W-1:0]  r_h;
    logic [DATA_W-1:0] r_dms;
    logic [DATA_W-1:0] r_pms;

    t_status           r_st;
    logic [IDW-1:0]    r_tid;
    logic              r_fired;
    logic [HDL_W-1:0]  r_fh;

    logic              r_ovalid;
    t_status           r_ost;
    logic [TID_W-1:0]  r_otid;
    logic              r_ofired;
    logic [HDL_W-1:0]  r_ofh;

    // Divider control.
    logic              div_start;
    logic [DATA_W-1:0] div_arg;
    logic              div_done;
    logic [DATA_W-1:0] div_q;

    // Memory write controls.
    logic              we_succ, we_delta, we_ent;
    logic [IDW-1:0]    wa_succ, wa_delta;
    logic [PW-1:0]     wd_succ;
    logic [DATA_W-1:0] wd_delta;

    logic              accept;
    logic              cur_ok;
    logic              prev_ok;
    logic              nxt_ok;
    logic [DATA_W:0]   walk_sum;
    logic              walk_on;
    logic [PW-1:0]     nxt_norm;
    logic [PW-1:0]     id_ext;
    logic              tgt_ok;
    logic [IDW-1:0]    tgt_id;
    logic              out_free;

    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign cur_ok   = r_cur < NO_TASK;
    assign prev_ok  = r_prev < NO_TASK;
    assign nxt_ok   = rd_succ < NO_TASK;
    assign nxt_norm = (r_nxt < NO_TASK) ? r_nxt : NO_TASK;
    assign id_ext   = PW'(r_id);
    assign walk_sum = {1'b0, r_sum} + {1'b0, rd_delta};
    assign walk_on  = cur_ok && ({1'b0, r_d} >= walk_sum);
    assign tgt_id   = IDW'(i_in.target_id);
    assign tgt_ok   = (32'(i_in.target_id) < MAX_TASKS) && r_in_use[tgt_id];
    assign out_free = !r_ovalid || o_out.ready;

    dlts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_arg),
        .i_divisor  (r_tick),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Next cursor and memory write selection.
    always_comb begin
        n_cur     = r_cur;
        div_start = 1'b0;
        div_arg   = r_dms;
        we_succ   = 1'b0;
        we_delta  = 1'b0;
        we_ent    = 1'b0;
        wa_succ   = r_id;
        wa_delta  = r_cur[IDW-1:0];
        wd_succ   = NO_TASK;
        wd_delta  = rd_delta;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cur = r_head;
                end
            end
            S_SRCH: begin
                if (!r_in_use[r_id]) begin
                    div_start = 1'b1;
                end
            end
            S_DIV_D: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_arg   = r_pms;
                end
            end
            S_DIV_P: begin
                if (div_done) begin
                    n_cur = r_head;
                end
            end
            S_L_WALK: begin
                if (walk_on) begin
                    n_cur = rd_succ;
                end else if (cur_ok) begin
                    we_delta = 1'b1;
                    wd_delta = rd_delta - (r_d - r_sum);
                end
            end
            S_L_ENT: begin
                we_ent   = 1'b1;
                we_succ  = 1'b1;
                wd_succ  = cur_ok ? r_cur : NO_TASK;
                we_delta = 1'b1;
                wa_delta = r_id;
                wd_delta = r_nd;
            end
            S_L_LNK: begin
                if (prev_ok) begin
                    we_succ = 1'b1;
                    wa_succ = r_prev[IDW-1:0];
                    wd_succ = id_ext;
                end
            end
            S_U_WALK: begin
                if (cur_ok && r_cur != id_ext) begin
                    n_cur = rd_succ;
                end else if (r_cur == id_ext && nxt_ok) begin
                    n_cur = rd_succ;
                end
            end
            S_U_ADD: begin
                we_delta = 1'b1;
                wd_delta = rd_delta + r_did;
            end
            S_U_FIX: begin
                if (prev_ok) begin
                    we_succ = 1'b1;
                    wa_succ = r_prev[IDW-1:0];
                    wd_succ = nxt_norm;
                end
                if (r_cmd == CMD_DISPATCH && r_p != '0) begin
                    n_cur = prev_ok ? r_head : nxt_norm;
                end
            end
            S_T_EX: begin
                if (rd_delta != '0) begin
                    we_delta = 1'b1;
                    wd_delta = rd_delta - DATA_W'(1);
                end
            end
            S_D_HEAD: begin
                n_cur = r_head;
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Entry memories: one write per array per cycle, registered read.
    always_ff @(posedge i_clk) begin
        if (we_succ) begin
            mem_succ[wa_succ] <= wd_succ;
        end
        if (we_delta) begin
            mem_delta[wa_delta] <= wd_delta;
        end
        if (we_ent) begin
            mem_per[r_id] <= r_p;
            mem_hdl[r_id] <= r_h;
        end
        rd_succ  <= mem_succ[n_cur[IDW-1:0]];
        rd_delta <= mem_delta[n_cur[IDW-1:0]];
        rd_per   <= mem_per[n_cur[IDW-1:0]];
        rd_hdl   <= mem_hdl[n_cur[IDW-1:0]];
    end

    // Sequencer, list state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_use <= '0;
            r_head   <= NO_TASK;
            r_count  <= '0;
            r_last   <= '0;
            r_due    <= 1'b0;
            r_tick   <= TICK_RESET;
            r_ovalid <= 1'b0;
            r_cur    <= NO_TASK;
        end else begin
            r_cur <= n_cur;
            if (i_cfg_we) begin
                r_tick <= i_cfg_wdata;
            end
            // In S_OUT the output register is reloaded below instead.
            if (r_ovalid && o_out.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd   <= i_in.command;
                        r_fired <= 1'b0;
                        r_fh    <= '0;
                        r_prev  <= NO_TASK;
                        r_h     <= i_in.handle;
                        r_dms   <= i_in.delay_ms;
                        r_pms   <= i_in.period_ms;
                        r_p     <= '0;
                        case (i_in.command)
                            CMD_TICK: begin
                                r_st  <= ST_OK;
                                r_tid <= '0;
                                // An empty list or a head already due is left alone.
                                r_state <= (r_head < NO_TASK && !r_due) ? S_T_EX : S_OUT;
                            end
                            CMD_ADD: begin
                                r_st    <= ST_OK;
                                r_tid   <= '0;
                                r_id    <= r_last;
                                r_n     <= '0;
                                r_state <= S_SRCH;
                            end
                            CMD_DELETE: begin
                                if (tgt_ok) begin
                                    r_st    <= ST_OK;
                                    r_id    <= tgt_id;
                                    r_tid   <= tgt_id;
                                    r_state <= S_U_WALK;
                                end else begin
                                    r_st    <= ST_NO_ID;
                                    r_tid   <= '0;
                                    r_state <= S_OUT;
                                end
                            end
                            default: begin
                                r_due <= 1'b0;
                                r_tid <= '0;
                                if (r_due && r_head < NO_TASK) begin
                                    r_st    <= ST_OK;
                                    r_state <= S_D_HEAD;
                                end else begin
                                    r_st    <= ST_NOT_DUE;
                                    r_state <= S_OUT;
                                end
                            end
                        endcase
                    end
                end
                S_SRCH: begin
                    // Round-robin scan for a free id, one id per cycle.
                    if (!r_in_use[r_id]) begin
                        r_last  <= r_id;
                        r_tid   <= r_id;
                        r_state <= S_DIV_D;
                    end else if (r_n == LAST_ID) begin
                        r_st    <= ST_FULL;
                        r_state <= S_OUT;
                    end else begin
                        r_n <= r_n + PW'(1);
                        r_id <= (PW'(r_id) == LAST_ID) ? '0 : r_id + IDW'(1);
                    end
                end
                S_DIV_D: begin
                    if (div_done) begin
                        r_d     <= div_q;
                        r_state <= S_DIV_P;
                    end
                end
                S_DIV_P: begin
                    if (div_done) begin
                        r_p     <= div_q;
                        r_sum   <= '0;
                        r_state <= S_L_WALK;
                    end
                end
                S_L_WALK: begin
                    // Walk past every entry whose deadline is not later.
                    if (walk_on) begin
                        r_sum  <= walk_sum[DATA_W-1:0];
                        r_prev <= r_cur;
                    end else begin
                        r_nd    <= r_d - r_sum;
                        r_state <= S_L_ENT;
                    end
                end
                S_L_ENT: begin
                    r_state <= S_L_LNK;
                end
                S_L_LNK: begin
                    if (!prev_ok) begin
                        r_head <= id_ext;
                    end
                    r_in_use[r_id] <= 1'b1;
                    r_count        <= r_count + PW'(1);
                    r_state        <= S_OUT;
                end
                S_U_WALK: begin
                    if (cur_ok && r_cur != id_ext) begin
                        r_prev <= r_cur;
                    end else begin
                        r_in_use[r_id] <= 1'b0;
                        if (r_cur != id_ext) begin
                            r_state <= S_OUT;
                        end else begin
                            r_nxt   <= rd_succ;
                            r_did   <= rd_delta;
                            r_state <= nxt_ok ? S_U_ADD : S_U_FIX;
                        end
                    end
                end
                S_U_ADD: begin
                    r_state <= S_U_FIX;
                end
                S_U_FIX: begin
                    if (!prev_ok) begin
                        r_head <= nxt_norm;
                        r_due  <= 1'b0;
                    end
                    if (r_count != '0) begin
                        r_count <= r_count - PW'(1);
                    end
                    // A periodic task goes back in one period later, same id.
                    if (r_cmd == CMD_DISPATCH && r_p != '0) begin
                        r_d     <= r_p;
                        r_sum   <= '0;
                        r_prev  <= NO_TASK;
                        r_state <= S_L_WALK;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_T_EX: begin
                    if (rd_delta == '0) begin
                        r_due <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_D_HEAD: begin
                    r_id    <= r_head[IDW-1:0];
                    r_tid   <= r_head[IDW-1:0];
                    r_p     <= rd_per;
                    r_h     <= rd_hdl;
                    r_fh    <= rd_hdl;
                    r_fired <= 1'b1;
                    r_state <= S_U_WALK;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ost    <= r_st;
                        r_otid   <= TID_W'(r_tid);
                        r_ofired <= r_fired;
                        r_ofh    <= r_fh;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.status       = r_ost;
    assign o_out.task_id      = r_otid;
    assign o_out.fired        = r_ofired;
    assign o_out.fired_handle = r_ofh;

    `DLTS_ASSERT_NEXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready)
    `DLTS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= NO_TASK)
    `DLTS_ASSERT_NOW(a_empty_match, r_state == S_IDLE, (r_head == NO_TASK) == (r_count == '0))
    `DLTS_ASSERT_NOW(a_due_has_head, r_due, r_head < NO_TASK)
endmodule

### sv/dlts_div.sv
// Restoring divider, one quotient bit per cycle, shared by delay and period.
// Depends on dlts_pkg.
module dlts_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [dlts_pkg::DATA_W-1:0]     i_dividend,
    input  logic [dlts_pkg::TICK_W-1:0]     i_divisor,
    output logic                            o_done,
    output logic [dlts_pkg::DATA_W-1:0]     o_quotient
);
    import dlts_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] r_q;
    logic [TICK_W-1:0] r_rem;
    logic [TICK_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [TICK_W:0]   shifted;
    logic              fits;

    assign shifted = {r_rem, r_q[DATA_W-1]};
    assign fits    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_W);
                r_q    <= i_dividend;
                r_rem  <= '0;
                // A zero tick length divides as one.
                r_div  <= (i_divisor == '0) ? TICK_W'(1) : i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? TICK_W'(shifted - {1'b0, r_div}) : shifted[TICK_W-1:0];
                r_q   <= {r_q[DATA_W-2:0], fits};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule
